@@ src/i2cbm_pkg.sv @@
// Shared types and constants for the bit-level I2C master.
package i2cbm_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic       scl;
    logic       sda_low;
    logic       busy;
    logic       done;
    logic       fail;
    logic [7:0] rdata;
    logic       rej;
  } res_t;

endpackage

@@ src/i2cbm_seq.sv @@
// Bus sequencer: configuration registers, sequence state and per-tick next-state logic.
module i2cbm_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [2:0]                     kind,
  input  logic [7:0]                     data_byte,
  input  logic                           master_ack,
  input  logic                           sda_level,
  input  logic                           cfg_write,
  input  logic [i2cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cbm_pkg::CFG_DATA_W-1:0] cfg_data,
  output i2cbm_pkg::res_t                res
);
  import i2cbm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_TPM   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = CFG_IDX_W'(1);

  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_START_A = 4'd1;
  localparam logic [3:0] PH_START_B = 4'd2;
  localparam logic [3:0] PH_STOP_A  = 4'd3;
  localparam logic [3:0] PH_STOP_B  = 4'd4;
  localparam logic [3:0] PH_STOPF_A = 4'd5;
  localparam logic [3:0] PH_STOPF_B = 4'd6;
  localparam logic [3:0] PH_WR_HIGH = 4'd7;
  localparam logic [3:0] PH_WR_LOW  = 4'd8;
  localparam logic [3:0] PH_ACK_A   = 4'd9;
  localparam logic [3:0] PH_ACK_B   = 4'd10;
  localparam logic [3:0] PH_POLL    = 4'd11;
  localparam logic [3:0] PH_RD_LOW  = 4'd12;
  localparam logic [3:0] PH_RD_HIGH = 4'd13;
  localparam logic [3:0] PH_MA_A    = 4'd14;
  localparam logic [3:0] PH_MA_B    = 4'd15;

  logic [15:0] tpm;
  logic [7:0]  poll_limit;

  logic [3:0]  phase,       phase_next;
  logic [3:0]  bit_count,   bit_count_next;
  logic [7:0]  shift_reg,   shift_reg_next;
  logic [18:0] delay_count, delay_count_next;
  logic [7:0]  poll_count,  poll_count_next;
  logic        scl_reg,     scl_reg_next;
  logic        sda_reg,     sda_reg_next;
  logic        ack_choice,  ack_choice_next;

  logic [18:0] d1, d2, d5, d6;
  logic [3:0]  bc_inc;
  logic [8:0]  poll_inc;
  logic        rej, done, fail;
  logic [7:0]  rd;

  // A rate of zero behaves as one tick per microsecond.
  assign d1 = (tpm == 16'd0) ? 19'd1 : {3'd0, tpm};
  assign d2 = d1 << 1;
  assign d5 = (d1 << 2) + d1;
  assign d6 = (d1 << 2) + (d1 << 1);

  assign bc_inc   = bit_count + 4'd1;
  assign poll_inc = {1'b0, poll_count} + 9'd1;

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    poll_count_next  = poll_count;
    scl_reg_next     = scl_reg;
    sda_reg_next     = sda_reg;
    ack_choice_next  = ack_choice;
    rej  = 1'b0;
    done = 1'b0;
    fail = 1'b0;
    rd   = 8'd0;
    if (phase == PH_IDLE) begin
      case (kind)
        KIND_START: begin
          sda_reg_next     = 1'b0;
          scl_reg_next     = 1'b1;
          delay_count_next = d5;
          phase_next       = PH_START_A;
        end
        KIND_STOP: begin
          scl_reg_next     = 1'b1;
          sda_reg_next     = 1'b1;
          delay_count_next = d6;
          phase_next       = PH_STOP_A;
        end
        KIND_WRITE: begin
          bit_count_next   = 4'd0;
          sda_reg_next     = ~data_byte[7];
          shift_reg_next   = {data_byte[6:0], 1'b0};
          scl_reg_next     = 1'b1;
          delay_count_next = d2;
          phase_next       = PH_WR_HIGH;
        end
        KIND_READ: begin
          ack_choice_next  = master_ack;
          shift_reg_next   = 8'd0;
          bit_count_next   = 4'd0;
          sda_reg_next     = 1'b0;
          scl_reg_next     = 1'b0;
          delay_count_next = d2;
          phase_next       = PH_RD_LOW;
        end
        default: begin
        end
      endcase
    end else begin
      rej = (kind == KIND_START) || (kind == KIND_STOP) ||
            (kind == KIND_WRITE) || (kind == KIND_READ);
      if (phase == PH_POLL) begin
        if (!sda_level) begin
          scl_reg_next = 1'b0;
          phase_next   = PH_IDLE;
          done         = 1'b1;
        end else if (poll_inc > {1'b0, poll_limit}) begin
          // The acknowledge timed out, so the bus is released with a stop.
          scl_reg_next     = 1'b1;
          sda_reg_next     = 1'b1;
          delay_count_next = d6;
          phase_next       = PH_STOPF_A;
        end else begin
          poll_count_next = poll_inc[7:0];
        end
      end else if (delay_count > 19'd1) begin
        delay_count_next = delay_count - 19'd1;
      end else begin
        delay_count_next = 19'd0;
        case (phase)
          PH_START_A: begin
            sda_reg_next     = 1'b1;
            delay_count_next = d6;
            phase_next       = PH_START_B;
          end
          PH_START_B: begin
            scl_reg_next = 1'b0;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          PH_STOP_A: begin
            sda_reg_next     = 1'b0;
            delay_count_next = d6;
            phase_next       = PH_STOP_B;
          end
          PH_STOPF_A: begin
            sda_reg_next     = 1'b0;
            delay_count_next = d6;
            phase_next       = PH_STOPF_B;
          end
          PH_STOP_B: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          PH_STOPF_B: begin
            fail       = 1'b1;
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          PH_WR_HIGH: begin
            scl_reg_next     = 1'b0;
            delay_count_next = d2;
            phase_next       = PH_WR_LOW;
          end
          PH_WR_LOW: begin
            bit_count_next = bc_inc;
            if (bc_inc < 4'd8) begin
              sda_reg_next     = ~shift_reg[7];
              shift_reg_next   = {shift_reg[6:0], 1'b0};
              scl_reg_next     = 1'b1;
              delay_count_next = d2;
              phase_next       = PH_WR_HIGH;
            end else begin
              sda_reg_next     = 1'b0;
              delay_count_next = d1;
              phase_next       = PH_ACK_A;
            end
          end
          PH_ACK_A: begin
            scl_reg_next     = 1'b1;
            delay_count_next = d1;
            phase_next       = PH_ACK_B;
          end
          PH_ACK_B: begin
            poll_count_next = 8'd0;
            phase_next      = PH_POLL;
          end
          PH_RD_LOW: begin
            scl_reg_next     = 1'b1;
            shift_reg_next   = {shift_reg[6:0], sda_level};
            delay_count_next = d1;
            phase_next       = PH_RD_HIGH;
          end
          PH_RD_HIGH: begin
            bit_count_next   = bc_inc;
            scl_reg_next     = 1'b0;
            delay_count_next = d2;
            if (bc_inc < 4'd8) begin
              phase_next = PH_RD_LOW;
            end else begin
              sda_reg_next = ack_choice;
              phase_next   = PH_MA_A;
            end
          end
          PH_MA_A: begin
            scl_reg_next     = 1'b1;
            delay_count_next = d5;
            phase_next       = PH_MA_B;
          end
          PH_MA_B: begin
            scl_reg_next = 1'b0;
            rd           = shift_reg;
            phase_next   = PH_IDLE;
            done         = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  assign res.scl     = scl_reg_next;
  assign res.sda_low = sda_reg_next;
  assign res.busy    = (phase_next != PH_IDLE);
  assign res.done    = done;
  assign res.fail    = fail;
  assign res.rdata   = rd;
  assign res.rej     = rej;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpm        <= 16'd1;
      poll_limit <= 8'd250;
    end else if (cfg_write) begin
      if (cfg_index == REG_TPM) begin
        tpm <= cfg_data;
      end else if (cfg_index == REG_LIMIT) begin
        poll_limit <= cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= 4'd0;
      shift_reg   <= 8'd0;
      delay_count <= 19'd0;
      poll_count  <= 8'd0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b0;
      ack_choice  <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      delay_count <= delay_count_next;
      poll_count  <= poll_count_next;
      scl_reg     <= scl_reg_next;
      sda_reg     <= sda_reg_next;
      ack_choice  <= ack_choice_next;
    end
  end

  // Every timed phase is entered with a nonzero delay and counts down to one.
  a_delay_live: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE && phase != PH_POLL) |-> (delay_count != 19'd0))
    else $error("timed phase with an empty delay counter");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= 4'd8)
    else $error("bit counter beyond one byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(phase) && $stable(delay_count) && $stable(shift_reg)))
    else $error("sequence state moved without a tick");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_IDLE && kind == KIND_START) |=>
      (phase == PH_START_A && scl_reg && !sda_reg))
    else $error("start command did not enter its first phase");

endmodule

@@ src/i2cbm_obuf.sv @@
// Two-entry result buffer: output register plus skid register.
module i2cbm_obuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i2cbm_pkg::res_t din,
  output logic            can_push,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cbm_pkg::res_t dout
);
  import i2cbm_pkg::*;

  logic out_vld;
  logic skid_vld;
  res_t out_data;
  res_t skid_data;
  logic pop;

  assign pop       = out_vld && out_ready;
  assign can_push  = !skid_vld;
  assign out_valid = out_vld;
  assign dout      = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (pop) begin
      // No push can coincide with a full skid stage.
      if (skid_vld) begin
        out_data <= skid_data;
        skid_vld <= 1'b0;
      end else if (push) begin
        out_data <= din;
      end else begin
        out_vld <= 1'b0;
      end
    end else if (push) begin
      if (out_vld) begin
        skid_data <= din;
        skid_vld  <= 1'b1;
      end else begin
        out_data <= din;
        out_vld  <= 1'b1;
      end
    end
  end

endmodule

@@ src/i2c_bit_level_master.sv @@
// Top level of the tick-driven bit-level I2C master.
//
// Each transfer on the input channel is one time tick. A tick may carry a
// command (start, stop, write byte, read byte) and always carries the sampled
// SDA level. Every accepted tick produces exactly one result transfer that
// shows the SCL level, the SDA pull-down, busy, done, acknowledge failure,
// received byte and whether a command was rejected because a sequence was
// already running.
// One tick is taken per clock cycle while in_ready is high; its result is
// registered before it reaches the output channel. The sequencer state
// updates once per accepted tick; results go into a two-entry output buffer.
// When the receiver stalls, one more tick is accepted into the skid stage,
// after which in_ready drops until the output drains.
// Configuration writes (index 0 ticks per microsecond, index 1 acknowledge
// poll limit) are always accepted; other indexes are ignored.
// A synchronous reset idles the bus with SCL high and SDA released, empties
// the output buffer and restores the register defaults (1 and 250).
module i2c_bit_level_master (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       kind,
  input  logic [7:0]                       data_byte,
  input  logic                             master_ack,
  input  logic                             sda_level,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             scl_level,
  output logic                             sda_drive_low,
  output logic                             busy_res,
  output logic                             done_res,
  output logic                             ack_failed,
  output logic [7:0]                       read_data,
  output logic                             rejected,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [i2cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cbm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import i2cbm_pkg::*;

  logic accept;
  res_t res;
  res_t res_out;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  i2cbm_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (kind),
    .data_byte  (data_byte),
    .master_ack (master_ack),
    .sda_level  (sda_level),
    .cfg_write  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res        (res)
  );

  i2cbm_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .din       (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (res_out)
  );

  assign scl_level     = res_out.scl;
  assign sda_drive_low = res_out.sda_low;
  assign busy_res      = res_out.busy;
  assign done_res      = res_out.done;
  assign ack_failed    = res_out.fail;
  assign read_data     = res_out.rdata;
  assign rejected      = res_out.rej;

endmodule
